// File: design/dpsp_pkg.sv
// Package for the dual PD speed profile controller: item types, configuration
// register codes and reset values, pipeline stage numbering.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps

package dpsp_pkg;

	// Pipeline stages, numbered from the input register.
	localparam int NSTAGE    = 9;
	localparam int STG_IN    = 0;
	localparam int STG_RECIP = 1;
	localparam int STG_PROD  = 2;
	localparam int STG_GYRO  = 3;
	localparam int STG_STATE = 4;
	localparam int STG_PART  = 5;
	localparam int STG_TERM  = 6;
	localparam int STG_SUM   = 7;
	localparam int STG_OUT   = 8;

	localparam int GYRO_DIVISOR_DEF      = 5700;
	localparam int DECEL_ROTATE_STEP_DEF = 256;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Opcode of an input item.
	localparam logic OP_RESET = 1'b1;

	// Rotational feedback source.
	localparam logic [1:0] FB_ENC_GYRO = 2'd0;
	localparam logic [1:0] FB_GYRO     = 2'd1;
	localparam logic [1:0] FB_ENC      = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_KP_FORWARD    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KD_FORWARD    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KP_ROTATE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KD_ROTATE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_FORWARD = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DECEL_FORWARD = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_ROTATE  = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_MODE = 3'd7;

	// Accumulated error limits, Q31.8.
	localparam logic signed [39:0] ERR_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [39:0] ERR_MIN = 40'sh80_0000_0000;

	typedef struct packed {
		logic               opcode;
		logic [31:0]        left_counter;
		logic [31:0]        right_counter;
		logic signed [31:0] gyro_rate;
		logic signed [15:0] target_forward;
		logic signed [15:0] target_rotate;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] left_drive;
		logic signed [15:0] right_drive;
		logic signed [31:0] travelled_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] kp_forward;
		logic [15:0] kd_forward;
		logic [15:0] kp_rotate;
		logic [15:0] kd_rotate;
		logic [15:0] accel_forward_step;
		logic [15:0] decel_forward_step;
		logic [15:0] accel_rotate_step;
		logic [1:0]  feedback_mode;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		kp_forward:         16'd512,
		kd_forward:         16'd1024,
		kp_rotate:          16'd256,
		kd_rotate:          16'd3072,
		accel_forward_step: 16'd29350,
		decel_forward_step: 16'd29350,
		accel_rotate_step:  16'd256,
		feedback_mode:      FB_ENC_GYRO
	};

	// Item after the gyro division, entering the state stage.
	typedef struct packed {
		logic               opcode;
		logic [31:0]        left_counter;
		logic [31:0]        right_counter;
		logic signed [31:0] gyro_q;
		logic signed [15:0] target_forward;
		logic signed [15:0] target_rotate;
	} tick_t;

	// Updated errors and their change since the previous tick.
	typedef struct packed {
		logic signed [39:0] err_forward;
		logic signed [40:0] derr_forward;
		logic signed [39:0] err_rotate;
		logic signed [40:0] derr_rotate;
		logic signed [31:0] travelled;
	} err_t;

	// PD sums in Q.16, before the final scaling.
	typedef struct packed {
		logic signed [57:0] pd_forward;
		logic signed [57:0] pd_rotate;
		logic signed [31:0] travelled;
	} pd_t;

	// Per-stage load enables and the valid bit of the item offered to each stage.
	typedef struct packed {
		logic [NSTAGE-1:0] en;
		logic [NSTAGE-1:0] vin;
	} pipe_ctl_t;

endpackage

// File: design/dual_pd_speed_profile_controller_unit.sv
// Top level of the dual PD speed profile controller: configuration registers,
// pipeline valid/stall control, and the four datapath sections. Depends on dpsp_pkg.
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Item
// cmd     | in        | cmd_valid, cmd_stall | cmd_t: opcode, counters, gyro rate, targets
// rsp     | out       | rsp_valid, rsp_stall | rsp_t: left/right drive, travelled count
// cfg     | in        | cfg_write            | cfg_index selects, cfg_data carries the value
//
// An item is accepted every cycle while cmd_stall is low. Its result is registered
// in each stage in turn, from the input register through to the result register.
// The rate is set by the profile state stage, which ramps both speeds and
// accumulates both errors in one combinational step; the gyro division and the PD
// multiplies are pipelined around it. The asynchronous reset clears every valid bit
// and the profile state and loads the gain and step reset values; no clearing pass
// follows. A stalled result holds the last stage while earlier stages keep filling
// empty slots, so cmd_stall rises only once all nine stages hold items.

module dual_pd_speed_profile_controller_unit import dpsp_pkg::*; #(
	parameter int GYRO_DIVISOR      = GYRO_DIVISOR_DEF,
	parameter int DECEL_ROTATE_STEP = DECEL_ROTATE_STEP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  cmd_t                   cmd,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output rsp_t                   rsp,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t              cfg_q;
	logic [NSTAGE-1:0] valid_q;
	pipe_ctl_t         ctl;
	tick_t             tick;
	err_t              err;
	pd_t               pd;

	// Configuration must be written only while no item is in flight (the block does not
	// enforce this), so the stages read these registers directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KP_FORWARD:    cfg_q.kp_forward         <= cfg_data;
				REG_KD_FORWARD:    cfg_q.kd_forward         <= cfg_data;
				REG_KP_ROTATE:     cfg_q.kp_rotate          <= cfg_data;
				REG_KD_ROTATE:     cfg_q.kd_rotate          <= cfg_data;
				REG_ACCEL_FORWARD: cfg_q.accel_forward_step <= cfg_data;
				REG_DECEL_FORWARD: cfg_q.decel_forward_step <= cfg_data;
				REG_ACCEL_ROTATE:  cfg_q.accel_rotate_step  <= cfg_data;
				REG_FEEDBACK_MODE: cfg_q.feedback_mode      <= cfg_data[1:0];
			endcase
		end
	end

	// A stage loads when it is empty or when its item moves on. Empty slots
	// collapse, so a stall at the output only reaches the input when the
	// whole pipeline is full.
	always_comb begin
		ctl.vin = {valid_q[NSTAGE-2:0], cmd_valid};
		ctl.en[NSTAGE-1] = !valid_q[NSTAGE-1] || !rsp_stall;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			ctl.en[k] = !valid_q[k] || ctl.en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < NSTAGE; k++) begin
				if (ctl.en[k]) begin
					valid_q[k] <= ctl.vin[k];
				end
			end
		end
	end

	assign cmd_stall = !ctl.en[STG_IN];
	assign rsp_valid = valid_q[STG_OUT];

	// Stages 1 to 4: input register and gyro rate / divisor.
	dpsp_front #(
		.GYRO_DIVISOR(GYRO_DIVISOR)
	) u_front (
		.clk (clk),
		.ctl (ctl),
		.cmd (cmd),
		.tick(tick)
	);

	// Stage 5: the only stage holding state across items.
	dpsp_state #(
		.DECEL_ROTATE_STEP(DECEL_ROTATE_STEP)
	) u_state (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.cfg   (cfg_q),
		.tick  (tick),
		.err   (err)
	);

	// Stages 6 to 8: gain products, split to keep each multiplier narrow.
	dpsp_pd u_pd (
		.clk(clk),
		.ctl(ctl),
		.cfg(cfg_q),
		.err(err),
		.pd (pd)
	);

	// Stage 9: result register.
	dpsp_mix u_mix (
		.clk(clk),
		.ctl(ctl),
		.pd (pd),
		.rsp(rsp)
	);

endmodule

// File: design/dpsp_front.sv
// Input register and gyro rate division by a constant (stages 1 to 4).
// Depends on dpsp_pkg.
`timescale 1ns / 1ps

module dpsp_front import dpsp_pkg::*; #(
	parameter int GYRO_DIVISOR = GYRO_DIVISOR_DEF
) (
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  cmd_t      cmd,
	output tick_t     tick
);

	localparam logic [15:0] DIV   = 16'(GYRO_DIVISOR);
	// floor(2^32 / divisor); the estimate it gives is low by at most one.
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / GYRO_DIVISOR);

	cmd_t        cmd_s1, cmd_s2, cmd_s3;
	logic        gneg_s1, gneg_s2, gneg_s3;
	logic [31:0] gabs_s1, gabs_s2, gabs_s3;
	logic [31:0] qest_s2, qest_s3;
	logic [47:0] qd_s3;
	tick_t       tick_s4;

	logic [64:0] recip_prod;
	logic [47:0] rem;
	logic [31:0] quo;

	assign recip_prod = {33'b0, gabs_s1} * {32'b0, RECIP};
	assign rem        = {16'b0, gabs_s3} - qd_s3;
	assign quo        = qest_s3 + 32'(rem >= {32'b0, DIV});

	always_ff @(posedge clk) begin
		if (ctl.en[STG_IN]) begin
			cmd_s1  <= cmd;
			gneg_s1 <= cmd.gyro_rate[31];
			gabs_s1 <= cmd.gyro_rate[31] ? 32'(-cmd.gyro_rate) : cmd.gyro_rate;
		end
		if (ctl.en[STG_RECIP]) begin
			cmd_s2  <= cmd_s1;
			gneg_s2 <= gneg_s1;
			gabs_s2 <= gabs_s1;
			qest_s2 <= recip_prod[63:32];
		end
		if (ctl.en[STG_PROD]) begin
			cmd_s3  <= cmd_s2;
			gneg_s3 <= gneg_s2;
			gabs_s3 <= gabs_s2;
			qest_s3 <= qest_s2;
			qd_s3   <= {16'b0, qest_s2} * {32'b0, DIV};
		end
		if (ctl.en[STG_GYRO]) begin
			tick_s4.opcode         <= cmd_s3.opcode;
			tick_s4.left_counter   <= cmd_s3.left_counter;
			tick_s4.right_counter  <= cmd_s3.right_counter;
			tick_s4.target_forward <= cmd_s3.target_forward;
			tick_s4.target_rotate  <= cmd_s3.target_rotate;
			tick_s4.gyro_q         <= gneg_s3 ? $signed(-quo) : $signed(quo);
		end
	end

	assign tick = tick_s4;

endmodule

// File: design/dpsp_state.sv
// Profile state stage: encoder deltas, speed ramps and error accumulation (stage 5).
// Depends on dpsp_pkg.
`timescale 1ns / 1ps

module dpsp_state import dpsp_pkg::*; #(
	parameter int DECEL_ROTATE_STEP = DECEL_ROTATE_STEP_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  cfg_t      cfg,
	input  tick_t     tick,
	output err_t      err
);

	localparam logic [15:0] DECEL = 16'(DECEL_ROTATE_STEP);

	// Move cur toward tgt by one step, stopping at tgt.
	function automatic logic signed [23:0] ramp(
		input logic signed [23:0] cur,
		input logic signed [23:0] tgt,
		input logic [15:0]        up,
		input logic [15:0]        down
	);
		logic signed [24:0] stepped;
		logic signed [23:0] res;
		stepped = '0;
		res     = cur;
		if (cur < tgt) begin
			stepped = 25'(cur) + $signed({9'b0, up});
			res     = (stepped > 25'(tgt)) ? tgt : stepped[23:0];
		end else if (cur > tgt) begin
			stepped = 25'(cur) - $signed({9'b0, down});
			res     = (stepped < 25'(tgt)) ? tgt : stepped[23:0];
		end
		return res;
	endfunction

	// err + speed - 256 * feedback, saturated to 40 bits.
	function automatic logic signed [39:0] accum(
		input logic signed [39:0] e,
		input logic signed [23:0] spd,
		input logic signed [33:0] fb
	);
		logic signed [43:0] sum;
		logic signed [39:0] res;
		sum = 44'(e) + 44'(spd) - (44'(fb) <<< 8);
		if (sum[43:39] == 5'b00000 || sum[43:39] == 5'b11111) begin
			res = sum[39:0];
		end else begin
			res = sum[43] ? ERR_MIN : ERR_MAX;
		end
		return res;
	endfunction

	// The previous error always equals the stored error, and the running
	// wheel totals always equal the last counter readings, so only these
	// registers are kept.
	logic [31:0]        last_left_q, last_right_q;
	logic signed [23:0] speed_forward_q, speed_rotate_q;
	logic signed [39:0] error_forward_q, error_rotate_q;
	err_t               err_s5;

	logic signed [31:0] dl, dr;
	logic signed [32:0] fb_x, fb_enc;
	logic signed [33:0] fb_w;
	logic signed [23:0] spd_f, spd_r;
	logic signed [39:0] ef, er;
	logic signed [32:0] tsum, tadj;
	logic               clear;

	assign clear  = (tick.opcode == OP_RESET);
	assign dl     = $signed(tick.left_counter - last_left_q);
	assign dr     = $signed(tick.right_counter - last_right_q);
	assign fb_x   = 33'(dr) + 33'(dl);
	assign fb_enc = 33'(dr) - 33'(dl);

	always_comb begin
		unique case (cfg.feedback_mode)
			FB_GYRO:     fb_w = 34'(tick.gyro_q);
			FB_ENC:      fb_w = 34'(fb_enc);
			FB_ENC_GYRO: fb_w = 34'(fb_enc) + 34'(tick.gyro_q);
			default:     fb_w = 34'(fb_enc) + 34'(tick.gyro_q);
		endcase
	end

	assign spd_f = ramp(speed_forward_q, $signed({tick.target_forward, 8'h00}),
		cfg.accel_forward_step, cfg.decel_forward_step);
	assign spd_r = ramp(speed_rotate_q, $signed({tick.target_rotate, 8'h00}),
		cfg.accel_rotate_step, DECEL);
	assign ef = accum(error_forward_q, spd_f, 34'(fb_x));
	assign er = accum(error_rotate_q, spd_r, fb_w);

	// Average of the two wheel totals, truncated toward zero.
	assign tsum = 33'($signed(tick.left_counter)) + 33'($signed(tick.right_counter));
	assign tadj = tsum + $signed({32'b0, tsum[32]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q     <= '0;
			last_right_q    <= '0;
			speed_forward_q <= '0;
			speed_rotate_q  <= '0;
			error_forward_q <= '0;
			error_rotate_q  <= '0;
		end else if (ctl.en[STG_STATE] && ctl.vin[STG_STATE]) begin
			if (clear) begin
				last_left_q     <= '0;
				last_right_q    <= '0;
				speed_forward_q <= '0;
				speed_rotate_q  <= '0;
				error_forward_q <= '0;
				error_rotate_q  <= '0;
			end else begin
				last_left_q     <= tick.left_counter;
				last_right_q    <= tick.right_counter;
				speed_forward_q <= spd_f;
				speed_rotate_q  <= spd_r;
				error_forward_q <= ef;
				error_rotate_q  <= er;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[STG_STATE]) begin
			if (clear) begin
				err_s5 <= '0;
			end else begin
				err_s5.err_forward  <= ef;
				err_s5.derr_forward <= 41'(ef) - 41'(error_forward_q);
				err_s5.err_rotate   <= er;
				err_s5.derr_rotate  <= 41'(er) - 41'(error_rotate_q);
				err_s5.travelled    <= tadj[32:1];
			end
		end
	end

	assign err = err_s5;

endmodule

// File: design/dpsp_pd.sv
// PD products: split partial products, term assembly and P plus D sums (stages 6 to 8).
// Depends on dpsp_pkg.
`timescale 1ns / 1ps

module dpsp_pd import dpsp_pkg::*; (
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  cfg_t      cfg,
	input  err_t      err,
	output pd_t       pd
);

	// Each 16 x 40 (P) or 16 x 41 (D) product is cut at bit 20: 16 x 20 low, 16 x 20 or 16 x 21 high.
	logic [35:0]        pf_lo_s6, df_lo_s6, pr_lo_s6, dr_lo_s6;
	logic signed [36:0] pf_hi_s6, pr_hi_s6;
	logic signed [37:0] df_hi_s6, dr_hi_s6;
	logic signed [31:0] trav_s6, trav_s7;
	logic signed [57:0] pf_s7, df_s7, pr_s7, dr_s7;
	pd_t                pd_s8;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_PART]) begin
			pf_lo_s6 <= {20'b0, cfg.kp_forward} * {16'b0, err.err_forward[19:0]};
			pf_hi_s6 <= $signed({1'b0, cfg.kp_forward}) * $signed(err.err_forward[39:20]);
			df_lo_s6 <= {20'b0, cfg.kd_forward} * {16'b0, err.derr_forward[19:0]};
			df_hi_s6 <= $signed({1'b0, cfg.kd_forward}) * $signed(err.derr_forward[40:20]);
			pr_lo_s6 <= {20'b0, cfg.kp_rotate} * {16'b0, err.err_rotate[19:0]};
			pr_hi_s6 <= $signed({1'b0, cfg.kp_rotate}) * $signed(err.err_rotate[39:20]);
			dr_lo_s6 <= {20'b0, cfg.kd_rotate} * {16'b0, err.derr_rotate[19:0]};
			dr_hi_s6 <= $signed({1'b0, cfg.kd_rotate}) * $signed(err.derr_rotate[40:20]);
			trav_s6  <= err.travelled;
		end
		if (ctl.en[STG_TERM]) begin
			pf_s7   <= (58'(pf_hi_s6) <<< 20) + $signed(58'(pf_lo_s6));
			df_s7   <= (58'(df_hi_s6) <<< 20) + $signed(58'(df_lo_s6));
			pr_s7   <= (58'(pr_hi_s6) <<< 20) + $signed(58'(pr_lo_s6));
			dr_s7   <= (58'(dr_hi_s6) <<< 20) + $signed(58'(dr_lo_s6));
			trav_s7 <= trav_s6;
		end
		if (ctl.en[STG_SUM]) begin
			pd_s8.pd_forward <= pf_s7 + df_s7;
			pd_s8.pd_rotate  <= pr_s7 + dr_s7;
			pd_s8.travelled  <= trav_s7;
		end
	end

	assign pd = pd_s8;

endmodule

// File: design/dpsp_mix.sv
// Output stage: scales the PD sums, mixes them into saturated drives (stage 9).
// Depends on dpsp_pkg.
`timescale 1ns / 1ps

module dpsp_mix import dpsp_pkg::*; (
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  pd_t       pd,
	output rsp_t      rsp
);

	localparam logic signed [15:0] DRIVE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] DRIVE_MIN = 16'sh8000;

	// Divide by 2^16, truncating toward zero.
	function automatic logic signed [41:0] scale(input logic signed [57:0] v);
		logic signed [57:0] biased;
		biased = v + (v[57] ? 58'sd65535 : 58'sd0);
		return biased[57:16];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [42:0] v);
		logic signed [15:0] res;
		if (v[42:15] == '0 || v[42:15] == '1) begin
			res = v[15:0];
		end else begin
			res = v[42] ? DRIVE_MIN : DRIVE_MAX;
		end
		return res;
	endfunction

	logic signed [41:0] pwm_x, pwm_w;
	rsp_t               rsp_s9;

	assign pwm_x = scale(pd.pd_forward);
	assign pwm_w = scale(pd.pd_rotate);

	always_ff @(posedge clk) begin
		if (ctl.en[STG_OUT]) begin
			rsp_s9.left_drive      <= sat16(43'(pwm_x) - 43'(pwm_w));
			rsp_s9.right_drive     <= sat16(43'(pwm_x) + 43'(pwm_w));
			rsp_s9.travelled_count <= pd.travelled;
		end
	end

	assign rsp = rsp_s9;

endmodule

// File: tb/tb.sv
// Self-checking testbench for dual_pd_speed_profile_controller_unit: drives control
// ticks and profile resets and predicts every drive and travelled count in the bench.
// Depends on dpsp_pkg for the item, configuration and register-index types.
`timescale 1ns / 1ps

module tb import dpsp_pkg::*;;

	localparam logic       OP_TICK           = 1'b0;
	// Mode code three is not named by the package; the block treats it as encoder plus gyro.
	localparam logic [1:0] FB_ALIAS_ENC_GYRO = 2'd3;
	localparam int         WATCHDOG_LIMIT    = 3000;
	localparam longint     ERR_HI            = ERR_MAX;
	localparam longint     ERR_LO            = ERR_MIN;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cmd_valid = 1'b0;
	logic                   cmd_stall;
	cmd_t                   cmd       = '0;
	logic                   rsp_valid;
	logic                   rsp_stall = 1'b0;
	rsp_t                   rsp;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	dual_pd_speed_profile_controller_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Mirror of the controller: gains and steps as last written, plus the profile state.
	cfg_t               gains = CFG_RESET;
	logic [31:0]        prev_left = '0, prev_right = '0;
	logic signed [31:0] sum_left = '0, sum_right = '0;
	longint             speed_fwd = 0, speed_rot = 0;
	longint             err_fwd = 0, err_rot = 0, prev_err_fwd = 0, prev_err_rot = 0;

	// Drives and travelled counts still owed by the block, oldest first.
	rsp_t expected_drives[$];
	int   failures = 0;
	int   idle_cycles = 0;

	// Idling switches for the two sides of the block.
	bit sender_gaps = 1'b0;
	bit sink_stalls = 1'b0;

	// Encoder and target trackers of the random driving sequences.
	logic [31:0] enc_left = '0, enc_right = '0;
	shortint     goal_fwd = 0, goal_rot = 0;

	function automatic int pick(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Moves a profile speed one step toward its goal without overshooting it.
	function automatic longint ramp_toward(longint cur, longint goal, longint up, longint down);
		if (cur < goal) begin
			cur += up;
			if (cur > goal)
				cur = goal;
		end else if (cur > goal) begin
			cur -= down;
			if (cur < goal)
				cur = goal;
		end
		return cur;
	endfunction

	function automatic void clear_profile();
		prev_left = '0;
		prev_right = '0;
		sum_left = '0;
		sum_right = '0;
		speed_fwd = 0;
		speed_rot = 0;
		err_fwd = 0;
		err_rot = 0;
		prev_err_fwd = 0;
		prev_err_rot = 0;
	endfunction

	// Advances the mirrored profile by one item and returns the drives it produces.
	function automatic rsp_t predict_drives(cmd_t c);
		rsp_t               r;
		logic signed [31:0] step_left, step_right;
		longint             dl, dr, fwd_fb, rot_fb, gyro_q, pd_fwd, pd_rot;
		r = '0;
		if (c.opcode == OP_RESET) begin
			clear_profile();
			return r;
		end
		step_left = c.left_counter - prev_left;
		step_right = c.right_counter - prev_right;
		dl = step_left;
		dr = step_right;
		prev_left = c.left_counter;
		prev_right = c.right_counter;
		sum_left = sum_left + step_left;
		sum_right = sum_right + step_right;
		r.travelled_count = 32'((longint'(sum_left) + longint'(sum_right)) / 2);

		speed_fwd = ramp_toward(speed_fwd, longint'($signed(c.target_forward)) * 256,
			longint'(gains.accel_forward_step), longint'(gains.decel_forward_step));
		speed_rot = ramp_toward(speed_rot, longint'($signed(c.target_rotate)) * 256,
			longint'(gains.accel_rotate_step), longint'(DECEL_ROTATE_STEP_DEF));

		fwd_fb = dr + dl;
		gyro_q = longint'($signed(c.gyro_rate)) / longint'(GYRO_DIVISOR_DEF);
		case (gains.feedback_mode)
			FB_GYRO: rot_fb = gyro_q;
			FB_ENC:  rot_fb = dr - dl;
			default: rot_fb = dr - dl + gyro_q;
		endcase

		err_fwd = clamp(err_fwd + speed_fwd - fwd_fb * 256, ERR_LO, ERR_HI);
		err_rot = clamp(err_rot + speed_rot - rot_fb * 256, ERR_LO, ERR_HI);
		pd_fwd = (longint'(gains.kp_forward) * err_fwd
			+ longint'(gains.kd_forward) * (err_fwd - prev_err_fwd)) / 65536;
		pd_rot = (longint'(gains.kp_rotate) * err_rot
			+ longint'(gains.kd_rotate) * (err_rot - prev_err_rot)) / 65536;
		prev_err_fwd = err_fwd;
		prev_err_rot = err_rot;

		r.left_drive = 16'(clamp(pd_fwd - pd_rot, -32768, 32767));
		r.right_drive = 16'(clamp(pd_fwd + pd_rot, -32768, 32767));
		return r;
	endfunction

	// Offers one item, waits until the block takes it and records the drives it owes.
	// The task returns at the accepting edge with valid still high, so that a following
	// item keeps valid up without a drop.
	task automatic issue_command(input cmd_t c);
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do
			@(negedge clk);
		while (cmd_stall);
		expected_drives.push_back(predict_drives(c));
		@(posedge clk);
	endtask

	task automatic tick(input logic [31:0] left, input logic [31:0] right,
			input logic signed [31:0] gyro, input logic signed [15:0] fwd,
			input logic signed [15:0] rot);
		cmd_t c;
		c.opcode = OP_TICK;
		c.left_counter = left;
		c.right_counter = right;
		c.gyro_rate = gyro;
		c.target_forward = fwd;
		c.target_rotate = rot;
		issue_command(c);
	endtask

	// A profile reset, with every other field all zeros or all ones.
	task automatic send_reset(input bit fill);
		cmd_t c;
		c = fill ? '1 : '0;
		c.opcode = OP_RESET;
		issue_command(c);
	endtask

	// Stops offering items and waits for the block to hand back everything it owes.
	task automatic settle();
		cmd_valid <= 1'b0;
		while (expected_drives.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	// Writes every register back to back; only called while the block is empty.
	task automatic load_settings(input cfg_t s);
		write_register(REG_KP_FORWARD, s.kp_forward);
		write_register(REG_KD_FORWARD, s.kd_forward);
		write_register(REG_KP_ROTATE, s.kp_rotate);
		write_register(REG_KD_ROTATE, s.kd_rotate);
		write_register(REG_ACCEL_FORWARD, s.accel_forward_step);
		write_register(REG_DECEL_FORWARD, s.decel_forward_step);
		write_register(REG_ACCEL_ROTATE, s.accel_rotate_step);
		// The upper data bits are junk; only the two mode bits are kept.
		write_register(REG_FEEDBACK_MODE, {14'($urandom), s.feedback_mode});
		@(posedge clk);
		cfg_write <= 1'b0;
		gains = s;
	endtask

	function automatic cfg_t random_settings(input logic [1:0] mode);
		cfg_t s;
		s.kp_forward = 16'($urandom_range(0, 4096));
		s.kd_forward = 16'($urandom_range(0, 8192));
		s.kp_rotate = 16'($urandom_range(0, 4096));
		s.kd_rotate = 16'($urandom_range(0, 8192));
		s.accel_forward_step = 16'($urandom);
		s.decel_forward_step = 16'($urandom);
		s.accel_rotate_step = 16'($urandom);
		s.feedback_mode = mode;
		return s;
	endfunction

	// Mostly a plausible drive: encoders follow the targets with a little slip and the
	// gyro agrees with the turn rate. The rest is profile resets and raw noise.
	function automatic cmd_t next_drive_command();
		cmd_t c;
		int   roll, step_l, step_r;
		roll = $urandom_range(0, 99);
		c.opcode = OP_TICK;
		if (roll < 4) begin
			c = cmd_t'({$urandom, $urandom, $urandom});
			c.opcode = OP_RESET;
			enc_left = '0;
			enc_right = '0;
			return c;
		end
		if (roll < 14) begin
			c.left_counter = $urandom;
			c.right_counter = $urandom;
			c.gyro_rate = $urandom;
			c.target_forward = 16'($urandom);
			c.target_rotate = 16'($urandom);
			enc_left = c.left_counter;
			enc_right = c.right_counter;
			return c;
		end
		if ($urandom_range(0, 24) == 0)
			goal_fwd = ($urandom_range(0, 9) == 0) ? shortint'($urandom) : shortint'(pick(-80, 80));
		if ($urandom_range(0, 24) == 0)
			goal_rot = ($urandom_range(0, 9) == 0) ? shortint'($urandom) : shortint'(pick(-30, 30));
		step_l = (int'(goal_fwd) - int'(goal_rot)) / 2 + pick(-3, 3);
		step_r = (int'(goal_fwd) + int'(goal_rot)) / 2 + pick(-3, 3);
		enc_left = enc_left + step_l;
		enc_right = enc_right + step_r;
		c.left_counter = enc_left;
		c.right_counter = enc_right;
		c.gyro_rate = int'(goal_rot) * GYRO_DIVISOR_DEF + pick(-6000, 6000);
		c.target_forward = goal_fwd;
		c.target_rotate = goal_rot;
		return c;
	endfunction

	// Random items, with idling, when enabled, switched on and off in stretches.
	task automatic run_random(input int count, input bit idling);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				sender_gaps = idling && ($urandom_range(0, 3) != 0);
				sink_stalls = idling && ($urandom_range(0, 3) != 0);
			end
			issue_command(next_drive_command());
		end
	endtask

	// Zeros, wrap-around, the largest encoder jumps in both directions (driving the forward
	// error into both its limits and the drives into saturation), gyro rounding toward
	// zero, odd negative travel, full-scale targets and profile resets.
	task automatic test_directed_cases();
		tick(32'd0, 32'd0, 0, 16'sd0, 16'sd0);
		tick(32'd10, 32'd12, 5700, 16'sd20, 16'sd1);
		tick(32'hFFFF_FFF0, 32'd14, -5699, -16'sd5, 16'sd0);
		tick(32'h0000_0010, 32'd16, -5700, -16'sd5, 16'sd0);
		tick(32'h8000_000F, 32'h8000_000F, 32'h7FFF_FFFF, 16'sd32767, 16'sd32767);
		tick(32'h0000_000E, 32'h0000_000E, 32'h7FFF_FFFF, 16'sd32767, 16'sd32767);
		tick(32'h8000_000E, 32'h8000_000E, 32'h8000_0000, -16'sd32768, -16'sd32768);
		tick(32'h0000_000E, 32'h0000_000E, 32'h8000_0000, -16'sd32768, -16'sd32768);
		send_reset(1'b1);
		tick(32'hFFFF_FFFF, 32'd0, 0, 16'sd0, 16'sd0);
		tick(32'hFFFF_FFFE, 32'd0, 0, 16'sd0, 16'sd0);
		tick(32'hFFFF_FFFD, 32'd0, 0, 16'sd0, 16'sd0);
		for (int i = 0; i < 3; i++)
			tick(32'hFFFF_FFFD, 32'd0, 0, 16'sd32767, -16'sd32768);
		for (int i = 0; i < 2; i++)
			tick(32'hFFFF_FFFD, 32'd0, 0, -16'sd32768, 16'sd32767);
		send_reset(1'b0);
		tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, -16'sd1, -16'sd1);
		settle();
	endtask

	// Every gain and step at zero, then at full scale with the spare mode code.
	task automatic test_gain_extremes();
		cfg_t s;
		s = '0;
		s.feedback_mode = FB_ENC_GYRO;
		load_settings(s);
		run_random(200, 1'b1);
		settle();
		s = '1;
		s.feedback_mode = FB_ALIAS_ENC_GYRO;
		load_settings(s);
		run_random(200, 1'b1);
		settle();
	endtask

	// Each rotational feedback source with random gains; the sender holds off until the
	// block is empty halfway through each phase.
	task automatic test_feedback_modes();
		logic [1:0] modes [4];
		modes = '{FB_ENC_GYRO, FB_GYRO, FB_ENC, FB_ALIAS_ENC_GYRO};
		foreach (modes[m]) begin
			load_settings(random_settings(modes[m]));
			run_random(115, 1'b1);
			settle();
			run_random(115, 1'b1);
			settle();
		end
	endtask

	// Back-to-back items at the reset gains with neither side idling.
	task automatic test_streaming();
		load_settings(CFG_RESET);
		run_random(350, 1'b0);
		settle();
	endtask

	// Output side: random stall bursts whenever enabled.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 16);
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Handshakes are judged at the falling edge, where everything driven at the rising
	// edge has settled; an item seen here is taken at the next rising edge.
	always @(negedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_drives.size() == 0) begin
					$error("result with no item outstanding: %p", rsp);
					failures++;
				end else begin
					want = expected_drives.pop_front();
					if (rsp.left_drive !== want.left_drive) begin
						$error("left_drive expected %0d actual %0d", want.left_drive,
							rsp.left_drive);
						failures++;
					end
					if (rsp.right_drive !== want.right_drive) begin
						$error("right_drive expected %0d actual %0d", want.right_drive,
							rsp.right_drive);
						failures++;
					end
					if (rsp.travelled_count !== want.travelled_count) begin
						$error("travelled_count expected %0d actual %0d",
							want.travelled_count, rsp.travelled_count);
						failures++;
					end
				end
			end
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_gain_extremes();
		test_feedback_modes();
		test_streaming();
		repeat (20) @(posedge clk);
		if (failures == 0 && expected_drives.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
design/dpsp_pkg.sv
design/dpsp_front.sv
design/dpsp_state.sv
design/dpsp_pd.sv
design/dpsp_mix.sv
design/dual_pd_speed_profile_controller_unit.sv
tb/tb.sv
